>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL. They compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> rtl/bmpv_pkg.sv
package bmpv_pkg;

   localparam int MAX_BOXES_DEF  = 16;
   localparam int COUNT_BITS_DEF = 16;
   localparam int RESULT_CAP     = 16;
   localparam int COORD_BITS     = 12;
   localparam int BOX_BITS       = 4 * COORD_BITS;
   localparam int CNT_REG_BITS   = 5;
   localparam int ID_BITS        = 4;
   localparam int OUT_VOTE_BITS  = 16;

   typedef enum logic [1:0] {
      OP_LOAD_PREV = 2'd0,
      OP_LOAD_CURR = 2'd1,
      OP_MATCH     = 2'd2,
      OP_FINISH    = 2'd3
   } opcode_type;

   localparam logic CSR_PREV_COUNT = 1'b0;
   localparam logic CSR_CURR_COUNT = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_VOTE,
      ST_FIN
   } state_type;

   // A box is packed as {x, y, width, height}. The right and bottom edges are
   // formed one bit wider so that they never wrap.
   function automatic logic box_holds(input logic [BOX_BITS-1:0]   box,
                                      input logic [COORD_BITS-1:0] px,
                                      input logic [COORD_BITS-1:0] py);
      logic [COORD_BITS-1:0] bx;
      logic [COORD_BITS-1:0] by;
      logic [COORD_BITS:0]   xe;
      logic [COORD_BITS:0]   ye;
      bx = box[4*COORD_BITS-1:3*COORD_BITS];
      by = box[3*COORD_BITS-1:2*COORD_BITS];
      xe = {1'b0, bx} + {1'b0, box[2*COORD_BITS-1:COORD_BITS]};
      ye = {1'b0, by} + {1'b0, box[COORD_BITS-1:0]};
      return (bx <= px) && ({1'b0, px} < xe) && (by <= py) && ({1'b0, py} < ye);
   endfunction

endpackage

>>> rtl/bmpv_ram.sv
module bmpv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read data holds while rd_en is low.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/box_match_by_point_votes_unit.sv
// Box association by keypoint votes. Load words write one previous-frame or
// current-frame box (x, y, width, height) and leave the unit ready for the next
// word. A match word carries one matched point pair: a single containment unit
// first tests the current point against every current box slot and then the
// previous point against every previous slot, and then the unit walks the vote
// memory with one read-modify-write per cycle over the box pairs in use, with a
// previous box that misses its point skipping its whole row. A finish word walks
// the whole vote memory, one entry per cycle, picks the best current box for each
// previous box in use, sends one result word per previous box in order and zeroes
// every counter behind it; that walk pauses while a result cannot be handed over.
// After reset the vote memory is cleared in a pass over every entry before the
// first word is taken. req_stall is high whenever a word is in progress. The
// result register is separate from the sequencer, so a new word is taken while
// the last result of a finish still waits.
`include "assert_macros.svh"

module box_match_by_point_votes_unit
   import bmpv_pkg::*;
#(
   parameter int MAX_BOXES  = MAX_BOXES_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_opcode,
   input  logic [ID_BITS-1:0]      req_box_index,
   input  logic [COORD_BITS-1:0]   req_box_x,
   input  logic [COORD_BITS-1:0]   req_box_y,
   input  logic [COORD_BITS-1:0]   req_box_width,
   input  logic [COORD_BITS-1:0]   req_box_height,
   input  logic [COORD_BITS-1:0]   req_prev_point_x,
   input  logic [COORD_BITS-1:0]   req_prev_point_y,
   input  logic [COORD_BITS-1:0]   req_curr_point_x,
   input  logic [COORD_BITS-1:0]   req_curr_point_y,

   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [ID_BITS-1:0]      rsp_prev_box_id,
   output logic [ID_BITS-1:0]      rsp_best_curr_index,
   output logic [OUT_VOTE_BITS-1:0] rsp_best_votes,
   output logic                    rsp_last,

   input  logic                    csr_write_en,
   input  logic                    csr_index,
   input  logic [CNT_REG_BITS-1:0] csr_write_data
);

   // Box slots are indexed with IW bits; the vote memory is addressed by
   // {previous slot, current slot}, so it holds VROW rows of VROW counters.
   localparam int IW     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int VROW   = 1 << IW;
   localparam int VAW    = 2 * IW;
   localparam int VDEPTH = 1 << VAW;
   localparam int LIM    = (MAX_BOXES < RESULT_CAP) ? MAX_BOXES : RESULT_CAP;
   localparam int CMPW   = ((IW > CNT_REG_BITS) ? IW : CNT_REG_BITS) + 1;
   localparam int CW     = COUNT_BITS;

   // Control registers.
   state_type               state_ff, state_in;
   logic [CNT_REG_BITS-1:0] prev_count_ff, prev_count_in;
   logic [CNT_REG_BITS-1:0] curr_count_ff, curr_count_in;
   logic [IW-1:0]           k_ff, k_in;
   logic                    side_ff, side_in;
   logic                    scan_done_ff, scan_done_in;
   logic                    sx_v_ff, sx_v_in;
   logic [IW-1:0]           vi_ff, vi_in;
   logic [IW-1:0]           vj_ff, vj_in;
   logic                    vp_v_ff, vp_v_in;
   logic [VAW-1:0]          f_cnt_ff, f_cnt_in;
   logic                    f_done_ff, f_done_in;
   logic                    fx_v_ff, fx_v_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [COORD_BITS-1:0]    ppx_ff, ppx_in, ppy_ff, ppy_in;
   logic [COORD_BITS-1:0]    cpx_ff, cpx_in, cpy_ff, cpy_in;
   logic [IW-1:0]            sx_k_ff, sx_k_in;
   logic                     sx_side_ff, sx_side_in;
   logic [VROW-1:0]          prev_hit_ff, prev_hit_in;
   logic [VROW-1:0]          curr_hit_ff, curr_hit_in;
   logic [VAW-1:0]           vp_addr_ff, vp_addr_in;
   logic [VAW-1:0]           fx_addr_ff, fx_addr_in;
   logic [CW-1:0]            best_ff, best_in;
   logic [IW-1:0]            best_idx_ff, best_idx_in;
   logic [ID_BITS-1:0]       rsp_id_ff, rsp_id_in;
   logic [ID_BITS-1:0]       rsp_idx_ff, rsp_idx_in;
   logic [OUT_VOTE_BITS-1:0] rsp_votes_ff, rsp_votes_in;
   logic                     rsp_last_ff, rsp_last_in;

   // Memory ports.
   logic                box_rd_en;
   logic                prev_we, curr_we;
   logic [IW-1:0]       box_waddr;
   logic [BOX_BITS-1:0] box_wdata;
   logic [BOX_BITS-1:0] prev_rd, curr_rd;
   logic                vwe, vre;
   logic [VAW-1:0]      vwaddr, vraddr;
   logic [CW-1:0]       vwdata, vote_rd;

   logic                    accept;
   logic                    slot_ok;
   logic [CNT_REG_BITS-1:0] np, nc;

   // Shared containment unit.
   logic [BOX_BITS-1:0]   cu_box;
   logic [COORD_BITS-1:0] cu_px, cu_py;
   logic                  cu_hit;

   // Finish walk signals.
   logic [IW-1:0] fi, fj;
   logic          f_consider;
   logic [CW-1:0] f_base, f_cand;
   logic [IW-1:0] f_base_idx, f_cand_idx;
   logic          f_row_end, f_emit, f_out_free, fin_stall;
   logic          v_hit;

   function automatic logic [CNT_REG_BITS-1:0] in_use(input logic [CNT_REG_BITS-1:0] r);
      if (r > CNT_REG_BITS'(LIM)) begin
         return CNT_REG_BITS'(LIM);
      end
      return r;
   endfunction

   assign np        = in_use(prev_count_ff);
   assign nc        = in_use(curr_count_ff);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);

   // Loads go straight into the box stores; a slot beyond the store is dropped.
   assign slot_ok   = (int'(req_box_index) < MAX_BOXES);
   assign box_waddr = IW'(req_box_index);
   assign box_wdata = {req_box_x, req_box_y, req_box_width, req_box_height};
   assign prev_we   = accept && (opcode_type'(req_opcode) == OP_LOAD_PREV) && slot_ok;
   assign curr_we   = accept && (opcode_type'(req_opcode) == OP_LOAD_CURR) && slot_ok;

   bmpv_ram #(.WIDTH(BOX_BITS), .DEPTH(VROW)) u_prev_boxes (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (box_waddr),
      .wr_data (box_wdata),
      .rd_en   (box_rd_en),
      .rd_addr (k_ff),
      .rd_data (prev_rd)
   );

   bmpv_ram #(.WIDTH(BOX_BITS), .DEPTH(VROW)) u_curr_boxes (
      .clock   (clock),
      .wr_en   (curr_we),
      .wr_addr (box_waddr),
      .wr_data (box_wdata),
      .rd_en   (box_rd_en),
      .rd_addr (k_ff),
      .rd_data (curr_rd)
   );

   bmpv_ram #(.WIDTH(CW), .DEPTH(VDEPTH)) u_votes (
      .clock   (clock),
      .wr_en   (vwe),
      .wr_addr (vwaddr),
      .wr_data (vwdata),
      .rd_en   (vre),
      .rd_addr (vraddr),
      .rd_data (vote_rd)
   );

   // The scan's second stage feeds either box store into the one containment unit.
   assign cu_box = sx_side_ff ? prev_rd : curr_rd;
   assign cu_px  = sx_side_ff ? ppx_ff : cpx_ff;
   assign cu_py  = sx_side_ff ? ppy_ff : cpy_ff;
   assign cu_hit = box_holds(cu_box, cu_px, cu_py);

   // Finish walk: second stage sees the counter read by the first stage, held in the vote memory's read register.
   assign fi         = fx_addr_ff[VAW-1:IW];
   assign fj         = fx_addr_ff[IW-1:0];
   assign f_consider = (CMPW'(fi) < CMPW'(np)) && (CMPW'(fj) < CMPW'(nc));
   assign f_base     = (fj == '0) ? '0 : best_ff;
   assign f_base_idx = (fj == '0) ? '0 : best_idx_ff;
   assign f_cand     = (f_consider && (vote_rd > f_base)) ? vote_rd : f_base;
   assign f_cand_idx = (f_consider && (vote_rd > f_base)) ? fj : f_base_idx;
   assign f_row_end  = (fj == '1);
   assign f_emit     = fx_v_ff && f_row_end && (CMPW'(fi) < CMPW'(np));
   assign f_out_free = !rsp_valid_ff || !rsp_stall;
   assign fin_stall  = f_emit && !f_out_free;

   assign v_hit = prev_hit_ff[vi_ff] && curr_hit_ff[vj_ff];

   always_comb begin
      state_in      = state_ff;
      prev_count_in = prev_count_ff;
      curr_count_in = curr_count_ff;
      k_in          = k_ff;
      side_in       = side_ff;
      scan_done_in  = scan_done_ff;
      sx_v_in       = 1'b0;
      sx_k_in       = sx_k_ff;
      sx_side_in    = sx_side_ff;
      prev_hit_in   = prev_hit_ff;
      curr_hit_in   = curr_hit_ff;
      vi_in         = vi_ff;
      vj_in         = vj_ff;
      vp_v_in       = 1'b0;
      vp_addr_in    = vp_addr_ff;
      f_cnt_in      = f_cnt_ff;
      f_done_in     = f_done_ff;
      fx_v_in       = 1'b0;
      fx_addr_in    = fx_addr_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      ppx_in        = ppx_ff;
      ppy_in        = ppy_ff;
      cpx_in        = cpx_ff;
      cpy_in        = cpy_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_id_in     = rsp_id_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_votes_in  = rsp_votes_ff;
      rsp_last_in   = rsp_last_ff;
      box_rd_en     = 1'b0;
      vre           = 1'b0;
      vraddr        = vp_addr_ff;
      vwe           = 1'b0;
      vwaddr        = vp_addr_ff;
      vwdata        = '0;

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_PREV_COUNT: prev_count_in = csr_write_data;
            CSR_CURR_COUNT: curr_count_in = csr_write_data;
         endcase
      end

      // Scan result lands in the hit vector of its side.
      if (sx_v_ff) begin
         if (sx_side_ff) begin
            prev_hit_in[sx_k_ff] = cu_hit;
         end else begin
            curr_hit_in[sx_k_ff] = cu_hit;
         end
      end

      // Write half of the vote read-modify-write; the counter saturates.
      if (vp_v_ff) begin
         vwe    = 1'b1;
         vwaddr = vp_addr_ff;
         vwdata = (vote_rd == '1) ? vote_rd : vote_rd + CW'(1);
      end

      unique case (state_ff)
         ST_CLEAR: begin
            vwe      = 1'b1;
            vwaddr   = f_cnt_ff;
            vwdata   = '0;
            f_cnt_in = f_cnt_ff + VAW'(1);
            if (f_cnt_ff == '1) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               unique case (opcode_type'(req_opcode))
                  OP_LOAD_PREV, OP_LOAD_CURR: begin
                     state_in = ST_IDLE;
                  end
                  OP_MATCH: begin
                     ppx_in       = req_prev_point_x;
                     ppy_in       = req_prev_point_y;
                     cpx_in       = req_curr_point_x;
                     cpy_in       = req_curr_point_y;
                     k_in         = '0;
                     side_in      = 1'b0;
                     scan_done_in = 1'b0;
                     state_in     = ST_SCAN;
                  end
                  OP_FINISH: begin
                     f_cnt_in  = '0;
                     f_done_in = 1'b0;
                     state_in  = ST_FIN;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // Current boxes first, then previous boxes, one slot per cycle.
            if (!scan_done_ff) begin
               box_rd_en  = 1'b1;
               sx_v_in    = 1'b1;
               sx_k_in    = k_ff;
               sx_side_in = side_ff;
               if (k_ff == IW'(MAX_BOXES - 1)) begin
                  k_in = '0;
                  if (side_ff) begin
                     scan_done_in = 1'b1;
                  end else begin
                     side_in = 1'b1;
                  end
               end else begin
                  k_in = k_ff + IW'(1);
               end
            end
            if (sx_v_ff && sx_side_ff && (sx_k_ff == IW'(MAX_BOXES - 1))) begin
               vi_in    = '0;
               vj_in    = '0;
               state_in = ((np != '0) && (nc != '0)) ? ST_VOTE : ST_IDLE;
            end
         end

         ST_VOTE: begin
            // A previous box that misses its point skips its whole row.
            if (!prev_hit_ff[vi_ff] ||
                ((CMPW'(vj_ff) + CMPW'(1)) == CMPW'(nc))) begin
               vj_in = '0;
               if ((CMPW'(vi_ff) + CMPW'(1)) == CMPW'(np)) begin
                  state_in = ST_IDLE;
               end else begin
                  vi_in = vi_ff + IW'(1);
               end
            end else begin
               vj_in = vj_ff + IW'(1);
            end
            if (v_hit) begin
               vre        = 1'b1;
               vraddr     = {vi_ff, vj_ff};
               vp_v_in    = 1'b1;
               vp_addr_in = {vi_ff, vj_ff};
            end
         end

         ST_FIN: begin
            if (fin_stall) begin
               fx_v_in = fx_v_ff;
            end else begin
               if (!f_done_ff) begin
                  vre        = 1'b1;
                  vraddr     = f_cnt_ff;
                  fx_v_in    = 1'b1;
                  fx_addr_in = f_cnt_ff;
                  f_cnt_in   = f_cnt_ff + VAW'(1);
                  if (f_cnt_ff == '1) begin
                     f_done_in = 1'b1;
                  end
               end
               if (fx_v_ff) begin
                  best_in     = f_cand;
                  best_idx_in = f_cand_idx;
                  vwe         = 1'b1;
                  vwaddr      = fx_addr_ff;
                  vwdata      = '0;
                  if (f_emit) begin
                     rsp_valid_in = 1'b1;
                     rsp_id_in    = ID_BITS'(fi);
                     rsp_idx_in   = ID_BITS'(f_cand_idx);
                     if (f_cand > CW'({OUT_VOTE_BITS{1'b1}})) begin
                        rsp_votes_in = '1;
                     end else begin
                        rsp_votes_in = OUT_VOTE_BITS'(f_cand);
                     end
                     rsp_last_in  = ((CMPW'(fi) + CMPW'(1)) == CMPW'(np));
                  end
                  if (fx_addr_ff == '1) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         prev_count_ff <= '0;
         curr_count_ff <= '0;
         k_ff          <= '0;
         side_ff       <= 1'b0;
         scan_done_ff  <= 1'b1;
         sx_v_ff       <= 1'b0;
         vi_ff         <= '0;
         vj_ff         <= '0;
         vp_v_ff       <= 1'b0;
         f_cnt_ff      <= '0;
         f_done_ff     <= 1'b1;
         fx_v_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prev_count_ff <= prev_count_in;
         curr_count_ff <= curr_count_in;
         k_ff          <= k_in;
         side_ff       <= side_in;
         scan_done_ff  <= scan_done_in;
         sx_v_ff       <= sx_v_in;
         vi_ff         <= vi_in;
         vj_ff         <= vj_in;
         vp_v_ff       <= vp_v_in;
         f_cnt_ff      <= f_cnt_in;
         f_done_ff     <= f_done_in;
         fx_v_ff       <= fx_v_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ppx_ff       <= ppx_in;
      ppy_ff       <= ppy_in;
      cpx_ff       <= cpx_in;
      cpy_ff       <= cpy_in;
      sx_k_ff      <= sx_k_in;
      sx_side_ff   <= sx_side_in;
      prev_hit_ff  <= prev_hit_in;
      curr_hit_ff  <= curr_hit_in;
      vp_addr_ff   <= vp_addr_in;
      fx_addr_ff   <= fx_addr_in;
      best_ff      <= best_in;
      best_idx_ff  <= best_idx_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_votes_ff <= rsp_votes_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_prev_box_id     = rsp_id_ff;
   assign rsp_best_curr_index = rsp_idx_ff;
   assign rsp_best_votes      = rsp_votes_ff;
   assign rsp_last            = rsp_last_ff;

   // A pending vote write only ever follows a vote sweep cycle.
   `ASSERT_NEXT(a_vote_write_after_sweep, clock, reset, state_ff != ST_VOTE, !vp_v_ff, "vote write outside vote sweep")
   // Results only come out of the finish walk.
   `ASSERT_IMPLY(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_FIN, "result word not from finish walk")
   // Neither pipeline carries a stage into the idle state.
   `ASSERT_IMPLY(a_idle_pipes_empty, clock, reset, state_ff == ST_IDLE, !fx_v_ff && !sx_v_ff, "pipeline stage left busy in idle")

endmodule

>>> sim/bmpv_checker.sv
`timescale 1ns / 1ps

// Watches the word, result and register ports of the box matcher, keeps its own
// copy of the box stores, the vote table and the count registers, and checks
// every result word against the queue of predicted pairings.
module bmpv_checker
   import bmpv_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [1:0]               req_opcode,
   input  logic [ID_BITS-1:0]       req_box_index,
   input  logic [COORD_BITS-1:0]    req_box_x,
   input  logic [COORD_BITS-1:0]    req_box_y,
   input  logic [COORD_BITS-1:0]    req_box_width,
   input  logic [COORD_BITS-1:0]    req_box_height,
   input  logic [COORD_BITS-1:0]    req_prev_point_x,
   input  logic [COORD_BITS-1:0]    req_prev_point_y,
   input  logic [COORD_BITS-1:0]    req_curr_point_x,
   input  logic [COORD_BITS-1:0]    req_curr_point_y,

   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [ID_BITS-1:0]       rsp_prev_box_id,
   input  logic [ID_BITS-1:0]       rsp_best_curr_index,
   input  logic [OUT_VOTE_BITS-1:0] rsp_best_votes,
   input  logic                     rsp_last,

   input  logic                     csr_write_en,
   input  logic                     csr_index,
   input  logic [CNT_REG_BITS-1:0]  csr_write_data,

   output int                       mismatch_count,
   output int                       results_pending
);

   localparam int SLOTS     = MAX_BOXES_DEF;
   localparam int VOTE_BITS = COUNT_BITS_DEF;
   localparam logic [VOTE_BITS-1:0] VOTE_CEILING = '1;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] w;
      logic [COORD_BITS-1:0] h;
   } rect_type;

   typedef struct packed {
      logic [ID_BITS-1:0]       prev_box_id;
      logic [ID_BITS-1:0]       best_curr_index;
      logic [OUT_VOTE_BITS-1:0] best_votes;
      logic                     last;
   } pairing_type;

   rect_type                prev_rects [SLOTS];
   rect_type                curr_rects [SLOTS];
   logic [VOTE_BITS-1:0]    votes [SLOTS][SLOTS];
   logic [CNT_REG_BITS-1:0] prev_count_reg;
   logic [CNT_REG_BITS-1:0] curr_count_reg;
   pairing_type             pairing_q [$];
   int                      mismatches;

   function automatic int slots_in_use(input logic [CNT_REG_BITS-1:0] reg_value);
      int n;
      n = int'(reg_value);
      if (n > SLOTS) n = SLOTS;
      if (n > RESULT_CAP) n = RESULT_CAP;
      return n;
   endfunction

   // Right and bottom edges are formed one bit wider so they never wrap.
   function automatic bit covers(input rect_type r, input logic [COORD_BITS-1:0] px,
                                 input logic [COORD_BITS-1:0] py);
      logic [COORD_BITS:0] right_edge;
      logic [COORD_BITS:0] bottom_edge;
      right_edge  = {1'b0, r.x} + {1'b0, r.w};
      bottom_edge = {1'b0, r.y} + {1'b0, r.h};
      return (r.x <= px) && ({1'b0, px} < right_edge) &&
             (r.y <= py) && ({1'b0, py} < bottom_edge);
   endfunction

   task automatic clear_votes();
      for (int i = 0; i < SLOTS; i++)
         for (int j = 0; j < SLOTS; j++)
            votes[i][j] = '0;
   endtask

   task automatic tally_match(input logic [COORD_BITS-1:0] ppx, input logic [COORD_BITS-1:0] ppy,
                              input logic [COORD_BITS-1:0] cpx, input logic [COORD_BITS-1:0] cpy);
      int np;
      int nc;
      np = slots_in_use(prev_count_reg);
      nc = slots_in_use(curr_count_reg);
      for (int i = 0; i < np; i++) begin
         if (covers(prev_rects[i], ppx, ppy)) begin
            for (int j = 0; j < nc; j++) begin
               if (covers(curr_rects[j], cpx, cpy) && votes[i][j] != VOTE_CEILING)
                  votes[i][j] = votes[i][j] + 1'b1;
            end
         end
      end
   endtask

   task automatic rank_frame();
      int                   np;
      int                   nc;
      logic [VOTE_BITS-1:0] top_votes;
      logic [ID_BITS-1:0]   top_index;
      pairing_type          p;
      np = slots_in_use(prev_count_reg);
      nc = slots_in_use(curr_count_reg);
      for (int i = 0; i < np; i++) begin
         top_votes = '0;
         top_index = '0;
         for (int j = 0; j < nc; j++) begin
            if (votes[i][j] > top_votes) begin
               top_votes = votes[i][j];
               top_index = ID_BITS'(j);
            end
         end
         p.prev_box_id     = ID_BITS'(i);
         p.best_curr_index = top_index;
         if (longint'(top_votes) > longint'({OUT_VOTE_BITS{1'b1}}))
            p.best_votes = '1;
         else
            p.best_votes = OUT_VOTE_BITS'(top_votes);
         p.last = (i == np - 1);
         pairing_q.insert(pairing_q.size(), p);
      end
      clear_votes();
   endtask

   task automatic check_result();
      pairing_type want;
      pairing_type got;
      got = {rsp_prev_box_id, rsp_best_curr_index, rsp_best_votes, rsp_last};
      if (pairing_q.size() == 0) begin
         if (mismatches < 10)
            $display("%0t: result word with nothing predicted: id %0d index %0d votes %0d last %0d",
                     $realtime, got.prev_box_id, got.best_curr_index, got.best_votes, got.last);
         mismatches++;
      end else begin
         want = pairing_q.pop_front();
         if (want.prev_box_id !== got.prev_box_id ||
             want.best_curr_index !== got.best_curr_index ||
             want.best_votes !== got.best_votes ||
             want.last !== got.last) begin
            if (mismatches < 10)
               $display("%0t: result mismatch: expected id %0d index %0d votes %0d last %0d, got id %0d index %0d votes %0d last %0d",
                        $realtime, want.prev_box_id, want.best_curr_index, want.best_votes,
                        want.last, got.prev_box_id, got.best_curr_index, got.best_votes,
                        got.last);
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) begin
            prev_rects[s] = '0;
            curr_rects[s] = '0;
         end
         clear_votes();
         prev_count_reg = '0;
         curr_count_reg = '0;
         pairing_q.delete();
      end else begin
         if (csr_write_en) begin
            if (csr_index == CSR_PREV_COUNT)
               prev_count_reg = csr_write_data;
            else
               curr_count_reg = csr_write_data;
         end
         // A result taken at this edge always belongs to an earlier finish.
         if (rsp_valid && !rsp_stall)
            check_result();
         if (req_valid && !req_stall) begin
            case (opcode_type'(req_opcode))
               OP_LOAD_PREV: prev_rects[req_box_index] =
                  {req_box_x, req_box_y, req_box_width, req_box_height};
               OP_LOAD_CURR: curr_rects[req_box_index] =
                  {req_box_x, req_box_y, req_box_width, req_box_height};
               OP_MATCH:     tally_match(req_prev_point_x, req_prev_point_y,
                                         req_curr_point_x, req_curr_point_y);
               OP_FINISH:    rank_frame();
               default: ;
            endcase
         end
      end
      mismatch_count  <= mismatches;
      results_pending <= pairing_q.size();
   end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

// Top of the box matcher testbench. It makes the stimulus, the receiver's
// stall pattern and the verdict; all prediction and checking happens in the
// checker instance that sits beside the block.
module tb
   import bmpv_pkg::*;
();

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] w;
      logic [COORD_BITS-1:0] h;
   } shape_type;

   localparam int SLOTS        = MAX_BOXES_DEF;
   localparam int COORD_TOP    = (1 << COORD_BITS) - 1;
   // Longest pause the block may still be busy after its last result: a match
   // word scans both box stores through the containment unit plus up to 256 vote
   // updates, and a finish walks all 256 table entries.
   localparam int SETTLE_CYCLES = 600;
   localparam int LONG_HOLD     = 1500;

   logic                     clock;
   logic                     reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [1:0]               req_opcode = '0;
   logic [ID_BITS-1:0]       req_box_index = '0;
   logic [COORD_BITS-1:0]    req_box_x = '0;
   logic [COORD_BITS-1:0]    req_box_y = '0;
   logic [COORD_BITS-1:0]    req_box_width = '0;
   logic [COORD_BITS-1:0]    req_box_height = '0;
   logic [COORD_BITS-1:0]    req_prev_point_x = '0;
   logic [COORD_BITS-1:0]    req_prev_point_y = '0;
   logic [COORD_BITS-1:0]    req_curr_point_x = '0;
   logic [COORD_BITS-1:0]    req_curr_point_y = '0;

   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [ID_BITS-1:0]       rsp_prev_box_id;
   logic [ID_BITS-1:0]       rsp_best_curr_index;
   logic [OUT_VOTE_BITS-1:0] rsp_best_votes;
   logic                     rsp_last;

   logic                     csr_write_en = 1'b0;
   logic                     csr_index = CSR_PREV_COUNT;
   logic [CNT_REG_BITS-1:0]  csr_write_data = '0;

   int                       mismatch_count;
   int                       results_pending;

   // Stimulus-side view of what has been loaded and how many boxes are live,
   // used only to aim match points into boxes so that votes actually pile up.
   shape_type                prev_shape [SLOTS];
   shape_type                curr_shape [SLOTS];
   int                       prev_live;
   int                       curr_live;

   int                       burst_left;
   int                       hold_asks = 0;

   box_match_by_point_votes_unit u_top (.*);

   bmpv_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Safety net: a healthy run finishes far sooner than this.
   initial begin
      #(10_000_000);
      $display("Some tests failed");
      $finish;
   end

   // Receiver. It switches between a few stall patterns of random length, and
   // on request from the stimulus holds the result port off for a long stretch
   // so that the finish walk pauses and the input side backs up.
   initial begin
      int hold_left;
      int hold_served;
      int mode;
      int mode_left;
      int phase;
      hold_left   = 0;
      hold_served = 0;
      mode        = 0;
      mode_left   = 0;
      phase       = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_asks != hold_served) begin
            hold_served = hold_asks;
            hold_left   = LONG_HOLD;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(10, 120);
            end
            mode_left--;
            phase++;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 1) == 1);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= (phase % 3 == 0);
            endcase
         end
      end
   end

   function automatic logic [COORD_BITS-1:0] any_coord();
      return COORD_BITS'($urandom_range(0, COORD_TOP));
   endfunction

   // Offers one word and waits for the edge that takes it. Between bursts the
   // sender goes quiet for a while; most gaps are short, some are long enough
   // to reach an idle block, and some bursts run on with no gap at all.
   task automatic put_word(input opcode_type op, input logic [ID_BITS-1:0] slot,
                           input logic [COORD_BITS-1:0] bx, input logic [COORD_BITS-1:0] by,
                           input logic [COORD_BITS-1:0] bw, input logic [COORD_BITS-1:0] bh,
                           input logic [COORD_BITS-1:0] ppx, input logic [COORD_BITS-1:0] ppy,
                           input logic [COORD_BITS-1:0] cpx, input logic [COORD_BITS-1:0] cpy);
      int gap;
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_box_index    <= slot;
      req_box_x        <= bx;
      req_box_y        <= by;
      req_box_width    <= bw;
      req_box_height   <= bh;
      req_prev_point_x <= ppx;
      req_prev_point_y <= ppy;
      req_curr_point_x <= cpx;
      req_curr_point_y <= cpy;
      do @(posedge clock); while (req_stall);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(0, 12);
         case ($urandom_range(0, 7))
            0, 1:    gap = 0;
            2:       gap = $urandom_range(50, 350);
            default: gap = $urandom_range(1, 6);
         endcase
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic load_box(input opcode_type op, input int slot, input int x, input int y,
                           input int w, input int h);
      shape_type s;
      s = {COORD_BITS'(x), COORD_BITS'(y), COORD_BITS'(w), COORD_BITS'(h)};
      if (op == OP_LOAD_PREV)
         prev_shape[slot] = s;
      else
         curr_shape[slot] = s;
      put_word(op, ID_BITS'(slot), s.x, s.y, s.w, s.h,
               any_coord(), any_coord(), any_coord(), any_coord());
   endtask

   // Point fields of a load and box fields of a match are don't-cares, so they
   // carry random bits as well.
   task automatic match_word(input int ppx, input int ppy, input int cpx, input int cpy);
      put_word(OP_MATCH, ID_BITS'($urandom_range(0, SLOTS - 1)),
               any_coord(), any_coord(), any_coord(), any_coord(),
               COORD_BITS'(ppx), COORD_BITS'(ppy), COORD_BITS'(cpx), COORD_BITS'(cpy));
   endtask

   task automatic finish_word();
      put_word(OP_FINISH, ID_BITS'($urandom_range(0, SLOTS - 1)),
               any_coord(), any_coord(), any_coord(), any_coord(),
               any_coord(), any_coord(), any_coord(), any_coord());
   endtask

   // Mostly moderate boxes, with some fully random ones, some of zero width or
   // height, and some hugging the far corner where the edge sums exceed 12 bits.
   task automatic load_random_box(input opcode_type op, input int slot);
      int x;
      int y;
      int w;
      int h;
      case ($urandom_range(0, 9))
         0: begin
            x = any_coord();
            y = any_coord();
            w = any_coord();
            h = any_coord();
         end
         1: begin
            x = any_coord();
            y = any_coord();
            w = ($urandom_range(0, 1) == 1) ? 0 : any_coord();
            h = (w == 0) ? any_coord() : 0;
         end
         2: begin
            x = COORD_TOP - $urandom_range(0, 3);
            y = $urandom_range(0, 3);
            w = COORD_TOP;
            h = COORD_TOP;
         end
         default: begin
            x = $urandom_range(0, 3400);
            y = $urandom_range(0, 3400);
            w = $urandom_range(1, 700);
            h = $urandom_range(1, 700);
         end
      endcase
      load_box(op, slot, x, y, w, h);
   endtask

   // Usually a point inside one of the live boxes, otherwise anywhere.
   task automatic pick_point(input bit from_prev, output int px, output int py);
      shape_type s;
      int        n;
      n  = from_prev ? prev_live : curr_live;
      px = any_coord();
      py = any_coord();
      if (n > 0 && $urandom_range(0, 4) != 0) begin
         s = from_prev ? prev_shape[$urandom_range(0, n - 1)]
                       : curr_shape[$urandom_range(0, n - 1)];
         if (s.w != 0 && s.h != 0) begin
            px = int'(s.x) + $urandom_range(0, int'(s.w) - 1);
            py = int'(s.y) + $urandom_range(0, int'(s.h) - 1);
            if (px > COORD_TOP) px = COORD_TOP;
            if (py > COORD_TOP) py = COORD_TOP;
         end
      end
   endtask

   task automatic random_match();
      int ppx;
      int ppy;
      int cpx;
      int cpy;
      pick_point(1'b1, ppx, ppy);
      pick_point(1'b0, cpx, cpy);
      match_word(ppx, ppy, cpx, cpy);
   endtask

   // Drops valid, waits for every predicted result, then lets the block run
   // out whatever word it may still be chewing on.
   task automatic settle_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_counts(input int prev_reg, input int curr_reg);
      settle_idle();
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_PREV_COUNT;
      csr_write_data <= CNT_REG_BITS'(prev_reg);
      @(posedge clock);
      csr_index      <= CSR_CURR_COUNT;
      csr_write_data <= CNT_REG_BITS'(curr_reg);
      @(posedge clock);
      csr_write_en   <= 1'b0;
      prev_live = (prev_reg > SLOTS) ? SLOTS : prev_reg;
      curr_live = (curr_reg > SLOTS) ? SLOTS : curr_reg;
   endtask

   // Counts for a random frame: mostly small, sometimes none, one, all, or a
   // register value beyond the number of slots.
   function automatic int pick_count();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return 1;
         2:       return SLOTS;
         3:       return $urandom_range(SLOTS + 1, (1 << CNT_REG_BITS) - 1);
         default: return $urandom_range(2, 8);
      endcase
   endfunction

   initial begin
      int random_words;
      int frame;
      int match_count;
      int tail;
      bit long_hold;
      random_words = 0;
      frame        = 0;
      burst_left   = 0;
      prev_live    = 0;
      curr_live    = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Every slot of both stores gets a box before any count makes it live,
      // so no match ever looks at a slot that was never written.
      for (int s = 0; s < SLOTS; s++) begin
         load_random_box(OP_LOAD_PREV, s);
         load_random_box(OP_LOAD_CURR, s);
      end

      // Directed frame. Previous box 0 covers 0..4094 on both axes, box 1 only
      // the single pixel at the far corner, box 2 has zero width. Current boxes
      // 0 and 1 are identical so their votes always tie, and box 2 is a one
      // pixel wide column at the right edge.
      set_counts(3, 3);
      load_box(OP_LOAD_PREV, 0, 0, 0, COORD_TOP, COORD_TOP);
      load_box(OP_LOAD_PREV, 1, COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP);
      load_box(OP_LOAD_PREV, 2, 100, 100, 0, 50);
      load_box(OP_LOAD_CURR, 0, 10, 10, 20, 20);
      load_box(OP_LOAD_CURR, 1, 10, 10, 20, 20);
      load_box(OP_LOAD_CURR, 2, COORD_TOP, 0, 1, COORD_TOP);
      match_word(COORD_TOP, COORD_TOP, COORD_TOP, 0);
      match_word(COORD_TOP - 1, COORD_TOP - 1, 15, 15);
      match_word(0, 0, 29, 29);
      // Points exactly on the right or bottom edge fall outside.
      match_word(COORD_TOP, 0, 30, 30);
      match_word(COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP);
      // Reloading a box in mid-frame must leave the votes alone.
      load_box(OP_LOAD_CURR, 2, 0, 0, COORD_TOP, COORD_TOP);
      match_word(2000, 3000, 5, 5);
      match_word(COORD_TOP, COORD_TOP, 0, 0);
      finish_word();
      // A second finish right away only sees the cleared table.
      finish_word();

      // No previous boxes in use: the finish sends nothing but still clears.
      set_counts(0, SLOTS);
      match_word(10, 10, 10, 10);
      finish_word();

      // A count above the slot number, and no current boxes at all.
      set_counts(SLOTS + 1, 0);
      random_match();
      finish_word();

      // Both registers at their all-ones value.
      set_counts((1 << CNT_REG_BITS) - 1, (1 << CNT_REG_BITS) - 1);
      match_word(0, 0, 0, 0);
      match_word(COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP);
      random_match();
      random_match();
      finish_word();

      // Random frames: a few reloads, a run of mostly aimed match pairs with
      // the odd reload mixed in, and a finish. Often the counts change, which
      // means a full drain first; otherwise frames run back to back. Two frames
      // hold the result port off across their finish while the sender keeps
      // offering a second frame's worth of words behind it.
      while (random_words < 140) begin
         if (frame == 0 || $urandom_range(0, 2) != 0)
            set_counts(pick_count(), pick_count());
         repeat ($urandom_range(0, 5)) begin
            load_random_box(($urandom_range(0, 1) == 1) ? OP_LOAD_CURR : OP_LOAD_PREV,
                            $urandom_range(0, SLOTS - 1));
            random_words++;
         end
         long_hold   = (frame == 2 || frame == 7);
         match_count = $urandom_range(3, 20);
         repeat (match_count) begin
            if ($urandom_range(0, 9) == 0)
               load_random_box(($urandom_range(0, 1) == 1) ? OP_LOAD_CURR : OP_LOAD_PREV,
                               $urandom_range(0, SLOTS - 1));
            else
               random_match();
            random_words++;
         end
         if (long_hold)
            hold_asks <= hold_asks + 1;
         finish_word();
         random_words++;
         if (long_hold) begin
            repeat (15) begin
               random_match();
               random_words++;
            end
            finish_word();
            random_words++;
         end
         frame++;
      end

      // Wind down: wait for the last results, bounded, then a latency's worth
      // of quiet cycles so that any stray result word is still caught.
      req_valid <= 1'b0;
      @(posedge clock);
      tail = 0;
      while (results_pending != 0 && tail < 50_000) begin
         @(posedge clock);
         tail++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && results_pending == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/bmpv_pkg.sv
rtl/bmpv_ram.sv
rtl/box_match_by_point_votes_unit.sv
sim/bmpv_checker.sv
sim/tb.sv
